/* design/scf_pkg.sv */
// ----------------------------------------------------------------------------
// scf_pkg
// Shared widths, defaults and request codes for the sigma clipping block.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

    localparam int SMP_W           = 16;
    localparam int K_W             = 4;
    localparam int MAX_SAMPLES_DEF = 4096;

    localparam logic [K_W-1:0] K_RESET = 4'd4;

    // request kinds carried on s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

`default_nettype wire

/* design/scf_div.sv */
// ----------------------------------------------------------------------------
// scf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 13
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_dif;
    logic             ge;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_dif = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                rem_reg <= ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* design/scf_sqrt.sv */
// ----------------------------------------------------------------------------
// scf_sqrt
// Digit-by-digit integer square root, one root bit per cycle, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_sqrt #(
    parameter int IN_W = 45
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [IN_W-1:0]        radicand,
    output logic                        done,
    output logic [(IN_W+1)/2-1:0]       root
);

    localparam int RT_W  = (IN_W + 1) / 2;
    localparam int PW    = 2 * RT_W;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [PW-1:0]    val_reg;
    logic [RT_W+1:0]  rem_reg;
    logic [RT_W-1:0]  root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RT_W+1:0]  rem_sh;
    logic [RT_W+1:0]  trial;
    logic             ge;

    always_comb begin
        rem_sh = {rem_reg[RT_W-1:0], val_reg[PW-1:PW-2]};
        trial  = {root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RT_W);
                val_reg  <= PW'(radicand);
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                val_reg  <= {val_reg[PW-3:0], 2'b00};
                rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[RT_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* design/sigma_clip_frame.sv */
// ----------------------------------------------------------------------------
// sigma_clip_frame
// Frame store with mean / standard deviation clamp on readout.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes the sample to the frame memory while there is
// room. The load with tlast set starts the statistics pass, during which no
// beat is taken: a bit-serial mean division (ACC_W = 32 plus the count width),
// one pass over the memory at one sample per cycle through the deviation
// pipeline, a variance division and a square root (RT_W = (ACC_W + 1) / 2),
// both skipped for a single sample, and the span and bounds states.
// A read beat (tuser 1) waits for the registered memory read and a free output
// register and returns one clamped sample; a read with no computed frame
// returns zero with tuser set. The memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_clip_frame #(
    parameter int MAX_SAMPLES = scf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // config: spread_factor
    input  wire logic                    cfg_we,
    input  wire logic [scf_pkg::K_W-1:0] cfg_wdata,
    // tdata: sample[15:0]; tuser: req_type; tlast: last_sample
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [15:0]             s_tdata,
    input  wire logic                    s_tuser,
    input  wire logic                    s_tlast,
    // tdata: clipped_value[15:0]; tuser: nothing_ready; tlast: frame_end
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [15:0]                  m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);

    import scf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SMP_W + CNT_W;
    localparam int ACC_W  = 2 * SMP_W + CNT_W;
    localparam int RT_W   = (ACC_W + 1) / 2;
    localparam int SPAN_W = K_W + RT_W;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MEAN_GO   = 4'd1;
    localparam logic [3:0] ST_MEAN_WAIT = 4'd2;
    localparam logic [3:0] ST_DEV       = 4'd3;
    localparam logic [3:0] ST_VAR_GO    = 4'd4;
    localparam logic [3:0] ST_VAR_WAIT  = 4'd5;
    localparam logic [3:0] ST_SQRT_GO   = 4'd6;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd7;
    localparam logic [3:0] ST_SPAN      = 4'd8;
    localparam logic [3:0] ST_BOUND     = 4'd9;
    localparam logic [3:0] ST_READ      = 4'd10;

    logic [SMP_W-1:0] mem [MAX_SAMPLES];
    logic [SMP_W-1:0] mem_q;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [3:0]        state_reg;
    logic [K_W-1:0]    k_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [SMP_W-1:0]  mean_reg;
    logic [SMP_W-1:0]  upper_reg;
    logic [SMP_W-1:0]  lower_reg;
    logic [CNT_W-1:0]  read_idx_reg;
    logic              frame_ready_reg;
    logic [CNT_W-1:0]  dev_idx_reg;
    logic              p1_v_reg;
    logic              p2_v_reg;
    logic              p3_v_reg;
    logic [SMP_W-1:0]  d_reg;
    logic [2*SMP_W-1:0] sq_reg;
    logic [RT_W-1:0]   dev_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              rd_nr_reg;

    logic              m_tvalid_reg;
    logic [SMP_W-1:0]  m_data_reg;
    logic              m_last_reg;
    logic              m_user_reg;

    logic              div_start;
    logic [ACC_W-1:0]  div_dvd;
    logic [CNT_W-1:0]  div_dvs;
    logic              div_done;
    logic [ACC_W-1:0]  div_quo;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [RT_W-1:0]   sqrt_root;

    logic              accept;
    logic              dev_issue;
    logic              out_free;
    logic [CNT_W-1:0]  eff_count;
    logic [SUM_W-1:0]  eff_sum;
    logic              room;
    logic [SMP_W-1:0]  clamp_val;
    logic [SPAN_W:0]   up_sum;
    logic [SPAN_W:0]   mean_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign dev_issue = (state_reg == ST_DEV) && (dev_idx_reg < count_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        eff_count = frame_ready_reg ? '0 : count_reg;
        eff_sum   = frame_ready_reg ? '0 : sum_reg;
        room      = (eff_count < CNT_W'(MAX_SAMPLES));
        rd_en     = dev_issue
                    || (accept && s_tuser == REQ_READ && frame_ready_reg);
        rd_addr   = (state_reg == ST_DEV) ? dev_idx_reg[ADDR_W-1:0]
                                          : read_idx_reg[ADDR_W-1:0];
        div_start = (state_reg == ST_MEAN_GO)
                    || (state_reg == ST_VAR_GO && count_reg != CNT_W'(1));
        div_dvd   = (state_reg == ST_MEAN_GO) ? ACC_W'(sum_reg) : acc_reg;
        div_dvs   = (state_reg == ST_MEAN_GO) ? count_reg : count_reg - 1'b1;
        sqrt_start = (state_reg == ST_SQRT_GO);
        clamp_val = mem_q;
        if (clamp_val > upper_reg) begin
            clamp_val = upper_reg;
        end
        if (clamp_val < lower_reg) begin
            clamp_val = lower_reg;
        end
        mean_ext = (SPAN_W+1)'(mean_reg);
        up_sum   = mean_ext + (SPAN_W+1)'(span_reg);
    end

    // frame memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == REQ_LOAD && room) begin
            mem[eff_count[ADDR_W-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    scf_div #(
        .DVD_W (ACC_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    scf_sqrt #(
        .IN_W (ACC_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quo),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // deviation pipeline: read, absolute difference, square, accumulate
    always_ff @(posedge aclk) begin
        d_reg  <= (mem_q >= mean_reg) ? mem_q - mean_reg : mean_reg - mem_q;
        sq_reg <= d_reg * d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            k_reg           <= K_RESET;
            count_reg       <= '0;
            sum_reg         <= '0;
            acc_reg         <= '0;
            mean_reg        <= '0;
            upper_reg       <= '0;
            lower_reg       <= '0;
            read_idx_reg    <= '0;
            frame_ready_reg <= 1'b0;
            dev_idx_reg     <= '0;
            p1_v_reg        <= 1'b0;
            p2_v_reg        <= 1'b0;
            p3_v_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            rd_nr_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                k_reg <= cfg_wdata;
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            p1_v_reg <= dev_issue;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (p3_v_reg) begin
                acc_reg <= acc_reg + ACC_W'(sq_reg);
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_tuser == REQ_LOAD) begin
                        if (frame_ready_reg) begin
                            frame_ready_reg <= 1'b0;
                            read_idx_reg    <= '0;
                        end
                        count_reg <= eff_count + CNT_W'(room);
                        sum_reg   <= room ? eff_sum + SUM_W'(s_tdata) : eff_sum;
                        if (s_tlast) begin
                            state_reg <= ST_MEAN_GO;
                        end
                    end else if (accept) begin
                        rd_nr_reg <= !frame_ready_reg;
                        state_reg <= ST_READ;
                    end
                end
                ST_MEAN_GO: begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT: begin
                    if (div_done) begin
                        mean_reg    <= div_quo[SMP_W-1:0];
                        acc_reg     <= '0;
                        dev_idx_reg <= '0;
                        state_reg   <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    if (dev_issue) begin
                        dev_idx_reg <= dev_idx_reg + 1'b1;
                    end else if (!p1_v_reg && !p2_v_reg && !p3_v_reg) begin
                        state_reg <= ST_VAR_GO;
                    end
                end
                ST_VAR_GO: begin
                    if (count_reg == CNT_W'(1)) begin
                        dev_reg   <= '0;
                        state_reg <= ST_SPAN;
                    end else begin
                        state_reg <= ST_VAR_WAIT;
                    end
                end
                ST_VAR_WAIT: begin
                    if (div_done) begin
                        state_reg <= ST_SQRT_GO;
                    end
                end
                ST_SQRT_GO: begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        dev_reg   <= sqrt_root;
                        state_reg <= ST_SPAN;
                    end
                end
                ST_SPAN: begin
                    span_reg  <= SPAN_W'(k_reg * dev_reg);
                    state_reg <= ST_BOUND;
                end
                ST_BOUND: begin
                    upper_reg <= (up_sum > (SPAN_W+1)'({SMP_W{1'b1}}))
                                 ? {SMP_W{1'b1}} : up_sum[SMP_W-1:0];
                    lower_reg <= ((SPAN_W+1)'(span_reg) >= mean_ext)
                                 ? '0 : mean_reg - span_reg[SMP_W-1:0];
                    read_idx_reg    <= '0;
                    frame_ready_reg <= 1'b1;
                    state_reg       <= ST_IDLE;
                end
                ST_READ: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_user_reg   <= rd_nr_reg;
                        if (rd_nr_reg) begin
                            m_data_reg <= '0;
                            m_last_reg <= 1'b0;
                        end else begin
                            m_data_reg <= clamp_val;
                            m_last_reg <= (read_idx_reg + 1'b1 == count_reg);
                            if (read_idx_reg + 1'b1 == count_reg) begin
                                frame_ready_reg <= 1'b0;
                                count_reg       <= '0;
                                sum_reg         <= '0;
                                read_idx_reg    <= '0;
                            end else begin
                                read_idx_reg <= read_idx_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_ready_reg |-> (read_idx_reg < count_reg))
        else $error("read index beyond frame while frame is ready");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count exceeds memory depth");

    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("empty read carries data or frame end");

    a_stats_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEV) |-> !frame_ready_reg)
        else $error("frame marked ready during deviation pass");
`endif

endmodule

`default_nettype wire
